FILE: hdl/ctfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctfr_pkg
// Shared types, codes and helpers of the CAN transport frame receiver.
// ----------------------------------------------------------------------------
package ctfr_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 64;
  localparam int FIFO_DEPTH          = 4;
  localparam int IN_TDATA_W          = 16;
  localparam int OUT_TDATA_W         = 152;
  localparam int CFG_ADDR_W          = 3;

  // register index, taken from address bit 2
  localparam logic REG_EXT_ADDR = 1'b0;
  localparam logic REG_BUF_SIZE = 1'b1;

  localparam logic [31:0] BUF_SIZE_RST = 32'd4095;

  // frame types
  localparam logic [1:0] KIND_SF = 2'd0;
  localparam logic [1:0] KIND_FF = 2'd1;
  localparam logic [1:0] KIND_CF = 2'd2;
  localparam logic [1:0] KIND_FC = 2'd3;

  // frame status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BAD     = 3'd1;
  localparam logic [2:0] ST_NOTSUP  = 3'd2;
  localparam logic [2:0] ST_NOBUF   = 3'd3;
  localparam logic [2:0] ST_NOSPACE = 3'd4;
  localparam logic [2:0] ST_SEQ     = 3'd5;

  // flow states
  localparam logic [1:0] FLOW_CTS  = 2'd0;
  localparam logic [1:0] FLOW_WAIT = 2'd1;
  localparam logic [1:0] FLOW_OVFL = 2'd2;

  // protocol control bytes
  localparam logic [7:0] PCI_FC_CTS  = 8'h30;
  localparam logic [7:0] PCI_FC_WAIT = 8'h31;
  localparam logic [7:0] PCI_FC_OVFL = 8'h32;
  localparam logic [3:0] PCI_SF      = 4'h0;
  localparam logic [3:0] PCI_FF      = 4'h1;
  localparam logic [3:0] PCI_CF      = 4'h2;

  localparam logic [7:0]  STMIN_US_LO  = 8'hf1;
  localparam logic [7:0]  STMIN_US_HI  = 8'hf9;
  localparam logic [7:0]  STMIN_MS_HI  = 8'h7f;
  localparam logic [16:0] STMIN_MAX_US = 17'd127000;

  localparam logic RES_PAYLOAD = 1'b0;
  localparam logic RES_STATUS  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic        last;
    logic [7:0]  pay_byte;
    logic [31:0] pay_off;
    logic [2:0]  status;
    logic [5:0]  byte_count;
    logic [31:0] msg_len;
    logic [31:0] rem_len;
    logic [1:0]  flow_status;
    logic [7:0]  block_size;
    logic [16:0] sep_us;
    logic [7:0]  addr_ext;
  } row_t;

  // STmin byte to microseconds
  function automatic logic [16:0] stmin_to_usec(input logic [7:0] p);
    logic [16:0] r;
    if (p == 8'h00) begin
      r = 17'd0;
    end else if (p >= STMIN_US_LO && p <= STMIN_US_HI) begin
      r = 17'(17'(p[3:0]) * 17'd100);
    end else if (p <= STMIN_MS_HI) begin
      r = 17'(17'(p[6:0]) * 17'd1000);
    end else begin
      r = STMIN_MAX_US;
    end
    return r;
  endfunction

endpackage

FILE: hdl/can_transport_frame_receiver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_transport_frame_receiver_unit
// Transport-layer receive parser: one CAN frame byte per beat, payload beats
// with message offsets and one status beat at the end of every frame.
// ----------------------------------------------------------------------------
// Data path: a byte's first result beat passes through the input register, then
// the result queue.
// Throughput: one input byte per cycle while the result queue holds at most two
// entries; the last byte of a frame adds a second result beat, so sustained rate is
// set by the output port at one beat per cycle through a four-entry result queue.
// Reset: synchronous, clears all parser state and the queue, buffer size 4095.
module can_transport_frame_receiver_unit #(
  parameter int MAX_FRAME_BYTES = ctfr_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ctfr_pkg::IN_TDATA_W-1:0]   in_tdata,   // frame_length[6:0], frame_byte[14:7]
  input  logic [1:0]                        in_tuser,   // command[1:0]
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ctfr_pkg::OUT_TDATA_W-1:0]  out_tdata,  // payload_byte, payload_offset,
                                                        // status, byte_count,
                                                        // message_length,
                                                        // remaining_length, flow_status,
                                                        // block_size, separation_usec,
                                                        // address_extension
  output logic [0:0]                        out_tuser,  // result_kind[0]
  output logic                              out_tlast,  // result_last
  // configuration
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [ctfr_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);

  localparam int LW    = $clog2(MAX_FRAME_BYTES + 1);
  localparam int PW    = $clog2(ctfr_pkg::FIFO_DEPTH);
  localparam int CW    = $clog2(ctfr_pkg::FIFO_DEPTH + 1);
  localparam logic [6:0] MAX_LEN7 = 7'(MAX_FRAME_BYTES);

  // configuration
  logic        ext_r;
  logic [31:0] buf_r;

  // input register
  logic        in_v_r;
  logic [1:0]  in_cmd_r;
  logic [6:0]  in_len_r;
  logic [7:0]  in_byte_r;

  // parser state
  logic [LW-1:0] pos_r,    pos_nxt;
  logic [2:0]    err_r,    err_nxt;
  logic [31:0]   hlen_r,   hlen_nxt;
  logic [31:0]   total_r,  total_nxt;
  logic [31:0]   rem_r,    rem_nxt;
  logic [3:0]    seq_r,    seq_nxt;
  logic [5:0]    copied_r, copied_nxt;
  logic [7:0]    cext_r,   cext_nxt;
  logic [1:0]    flow_r,   flow_nxt;
  logic [7:0]    fbs_r,    fbs_nxt;
  logic [16:0]   fsep_r,   fsep_nxt;
  logic [1:0]    kind_r,   kind_nxt;
  logic [LW-1:0] len_r,    len_nxt;
  logic [7:0]    pext_r,   pext_nxt;
  logic          hdone_r,  hdone_nxt;

  logic          push_pay, push_st;
  logic [7:0]    pay_byte;
  logic [31:0]   pay_off;
  logic [LW-1:0] rel;
  logic [6:0]    fl_w;
  logic [7:0]    sf_lim;

  // result queue
  ctfr_pkg::row_t fifo_r [ctfr_pkg::FIFO_DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  cnt_r;
  ctfr_pkg::row_t pay_row, st_row, row0, rd_row;
  logic [1:0]     n_push;
  logic           advance, pop, in_acc, cfg_wr;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == ctfr_pkg::REG_BUF_SIZE) ? buf_r : {31'b0, ext_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_r <= 1'b0;
      buf_r <= ctfr_pkg::BUF_SIZE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        ctfr_pkg::REG_EXT_ADDR: ext_r <= cfg_pwdata[0];
        ctfr_pkg::REG_BUF_SIZE: buf_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // input register
  // --------------------------------------------------------------------------
  assign advance   = in_v_r && (cnt_r <= CW'(ctfr_pkg::FIFO_DEPTH - 2));
  assign in_tready = !in_v_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_acc) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_cmd_r  <= in_tuser;
      in_len_r  <= in_tdata[6:0];
      in_byte_r <= in_tdata[14:7];
    end
  end

  // --------------------------------------------------------------------------
  // frame parser
  // --------------------------------------------------------------------------
  always_comb begin
    pos_nxt    = pos_r;
    err_nxt    = err_r;
    hlen_nxt   = hlen_r;
    total_nxt  = total_r;
    rem_nxt    = rem_r;
    seq_nxt    = seq_r;
    copied_nxt = copied_r;
    cext_nxt   = cext_r;
    flow_nxt   = flow_r;
    fbs_nxt    = fbs_r;
    fsep_nxt   = fsep_r;
    kind_nxt   = kind_r;
    len_nxt    = len_r;
    pext_nxt   = pext_r;
    hdone_nxt  = hdone_r;
    push_pay   = 1'b0;
    push_st    = 1'b0;
    pay_byte   = 8'd0;
    pay_off    = 32'd0;

    // latch frame type and length on the first byte
    fl_w = (in_len_r == 7'd0) ? 7'd1 : in_len_r;
    if (fl_w > MAX_LEN7) fl_w = MAX_LEN7;
    if (pos_r == '0) begin
      kind_nxt   = in_cmd_r;
      len_nxt    = LW'(fl_w);
      err_nxt    = ctfr_pkg::ST_OK;
      hlen_nxt   = 32'd0;
      copied_nxt = 6'd0;
      hdone_nxt  = 1'b0;
    end

    rel    = pos_r - LW'(ext_r);
    sf_lim = 8'(len_nxt) - 8'd2 - 8'(ext_r);

    if (ext_r && pos_r == '0) begin
      pext_nxt = in_byte_r;
      if (kind_nxt == ctfr_pkg::KIND_FC) cext_nxt = in_byte_r;
    end else if (err_nxt == ctfr_pkg::ST_OK) begin
      case (kind_nxt)
        ctfr_pkg::KIND_SF: begin
          if (hdone_nxt) begin
            if ({26'b0, copied_nxt} < hlen_nxt) begin
              push_pay   = 1'b1;
              pay_byte   = in_byte_r;
              pay_off    = {26'b0, copied_nxt};
              copied_nxt = copied_nxt + 6'd1;
            end
          end else if (rel == '0) begin
            if (in_byte_r[7:4] != ctfr_pkg::PCI_SF) begin
              err_nxt = ctfr_pkg::ST_BAD;
            end else begin
              if (ext_r) cext_nxt = pext_nxt;
              if (len_nxt <= LW'(8)) begin
                hlen_nxt  = {28'b0, in_byte_r[3:0]};
                hdone_nxt = 1'b1;
                if (in_byte_r[3:0] == 4'd0 || in_byte_r[3:0] > (4'd7 - 4'(ext_r)))
                  err_nxt = ctfr_pkg::ST_NOTSUP;
                else if (hlen_nxt > buf_r)
                  err_nxt = ctfr_pkg::ST_NOBUF;
              end
            end
          end else begin
            // escaped length byte
            hlen_nxt  = {24'b0, in_byte_r};
            hdone_nxt = 1'b1;
            if (in_byte_r <= (8'd7 - 8'(ext_r)) || in_byte_r > sf_lim)
              err_nxt = ctfr_pkg::ST_NOTSUP;
            else if (hlen_nxt > buf_r)
              err_nxt = ctfr_pkg::ST_NOBUF;
          end
        end
        ctfr_pkg::KIND_FF: begin
          if (hdone_nxt) begin
            if (rem_nxt != 32'd0) begin
              push_pay = 1'b1;
              pay_byte = in_byte_r;
              pay_off  = total_nxt - rem_nxt;
              rem_nxt  = rem_nxt - 32'd1;
              copied_nxt = copied_nxt + 6'd1;
            end
          end else begin
            if (rel == '0) begin
              if (in_byte_r[7:4] != ctfr_pkg::PCI_FF) begin
                err_nxt = ctfr_pkg::ST_BAD;
              end else begin
                if (ext_r) cext_nxt = pext_nxt;
                hlen_nxt = {20'b0, in_byte_r[3:0], 8'b0};
              end
            end else if (rel == LW'(1)) begin
              hlen_nxt  = hlen_nxt | {24'b0, in_byte_r};
              hdone_nxt = (hlen_nxt != 32'd0);
            end else begin
              hlen_nxt  = {hlen_nxt[23:0], in_byte_r};
              hdone_nxt = (rel == LW'(5));
            end
            // header complete: check space and open the message
            if (hdone_nxt) begin
              if (hlen_nxt > buf_r) begin
                err_nxt = ctfr_pkg::ST_NOSPACE;
              end else begin
                total_nxt = hlen_nxt;
                rem_nxt   = hlen_nxt;
                seq_nxt   = 4'd1;
              end
            end
          end
        end
        ctfr_pkg::KIND_CF: begin
          if (hdone_nxt) begin
            if (rem_nxt != 32'd0) begin
              push_pay = 1'b1;
              pay_byte = in_byte_r;
              pay_off  = total_nxt - rem_nxt;
              rem_nxt  = rem_nxt - 32'd1;
              copied_nxt = copied_nxt + 6'd1;
            end
          end else if (in_byte_r[7:4] != ctfr_pkg::PCI_CF) begin
            err_nxt = ctfr_pkg::ST_BAD;
          end else if (in_byte_r[3:0] != seq_nxt) begin
            err_nxt = ctfr_pkg::ST_SEQ;
          end else begin
            seq_nxt   = seq_nxt + 4'd1;
            if (ext_r) cext_nxt = pext_nxt;
            hdone_nxt = 1'b1;
          end
        end
        default: begin
          if (rel == '0) begin
            if (in_byte_r == ctfr_pkg::PCI_FC_CTS)       flow_nxt = ctfr_pkg::FLOW_CTS;
            else if (in_byte_r == ctfr_pkg::PCI_FC_WAIT) flow_nxt = ctfr_pkg::FLOW_WAIT;
            else if (in_byte_r == ctfr_pkg::PCI_FC_OVFL) flow_nxt = ctfr_pkg::FLOW_OVFL;
            else                                         err_nxt  = ctfr_pkg::ST_BAD;
          end else if (rel == LW'(1)) begin
            fbs_nxt = in_byte_r;
          end else if (rel == LW'(2)) begin
            fsep_nxt  = ctfr_pkg::stmin_to_usec(in_byte_r);
            hdone_nxt = 1'b1;
          end
        end
      endcase
    end

    // end of frame: close with a status beat
    if (({1'b0, pos_r} + (LW + 1)'(1)) >= {1'b0, len_nxt}) begin
      push_st = 1'b1;
      if (!hdone_nxt && err_nxt == ctfr_pkg::ST_OK) err_nxt = ctfr_pkg::ST_BAD;
      if (kind_nxt == ctfr_pkg::KIND_SF && err_nxt == ctfr_pkg::ST_OK) begin
        total_nxt = 32'd0;
        rem_nxt   = 32'd0;
        flow_nxt  = ctfr_pkg::FLOW_CTS;
        fbs_nxt   = 8'd0;
        fsep_nxt  = 17'd0;
      end
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_r + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      err_r    <= ctfr_pkg::ST_OK;
      hlen_r   <= 32'd0;
      total_r  <= 32'd0;
      rem_r    <= 32'd0;
      seq_r    <= 4'd0;
      copied_r <= 6'd0;
      cext_r   <= 8'd0;
      flow_r   <= ctfr_pkg::FLOW_CTS;
      fbs_r    <= 8'd0;
      fsep_r   <= 17'd0;
      kind_r   <= ctfr_pkg::KIND_SF;
      len_r    <= LW'(1);
      pext_r   <= 8'd0;
      hdone_r  <= 1'b0;
    end else if (advance) begin
      pos_r    <= pos_nxt;
      err_r    <= err_nxt;
      hlen_r   <= hlen_nxt;
      total_r  <= total_nxt;
      rem_r    <= rem_nxt;
      seq_r    <= seq_nxt;
      copied_r <= copied_nxt;
      cext_r   <= cext_nxt;
      flow_r   <= flow_nxt;
      fbs_r    <= fbs_nxt;
      fsep_r   <= fsep_nxt;
      kind_r   <= kind_nxt;
      len_r    <= len_nxt;
      pext_r   <= pext_nxt;
      hdone_r  <= hdone_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // result queue
  // --------------------------------------------------------------------------
  always_comb begin
    pay_row          = '0;
    pay_row.kind     = ctfr_pkg::RES_PAYLOAD;
    pay_row.pay_byte = pay_byte;
    pay_row.pay_off  = pay_off;

    st_row             = '0;
    st_row.kind        = ctfr_pkg::RES_STATUS;
    st_row.last        = 1'b1;
    st_row.status      = err_nxt;
    st_row.byte_count  = copied_nxt;
    st_row.msg_len     = ((kind_nxt == ctfr_pkg::KIND_SF || kind_nxt == ctfr_pkg::KIND_FF)
                          && hdone_nxt) ? hlen_nxt : total_nxt;
    st_row.rem_len     = rem_nxt;
    st_row.flow_status = flow_nxt;
    st_row.block_size  = fbs_nxt;
    st_row.sep_us      = fsep_nxt;
    st_row.addr_ext    = cext_nxt;

    row0   = push_pay ? pay_row : st_row;
    n_push = {1'b0, push_pay} + {1'b0, push_st};
  end

  assign pop = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (advance && n_push != 2'd0) fifo_r[wr_ptr_r] <= row0;
    if (advance && n_push == 2'd2) fifo_r[wr_ptr_r + PW'(1)] <= st_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (advance) wr_ptr_r <= wr_ptr_r + PW'(n_push);
      if (pop)     rd_ptr_r <= rd_ptr_r + PW'(1);
      cnt_r <= cnt_r + (advance ? CW'(n_push) : CW'(0)) - CW'(pop);
    end
  end

  assign rd_row     = fifo_r[rd_ptr_r];
  assign out_tvalid = (cnt_r != '0);
  assign out_tuser  = rd_row.kind;
  assign out_tlast  = rd_row.last;
  assign out_tdata  = {4'b0, rd_row.addr_ext, rd_row.sep_us, rd_row.block_size,
                       rd_row.flow_status, rd_row.rem_len, rd_row.msg_len,
                       rd_row.byte_count, rd_row.status, rd_row.pay_off,
                       rd_row.pay_byte};

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(ctfr_pkg::FIFO_DEPTH))
    else $error("result queue overfilled");

  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r != '0 |-> pos_r < len_r)
    else $error("byte position past frame length");

  a_status_closes: assert property (@(posedge clk) disable iff (!rst_n)
    advance && push_st |=> pos_r == '0)
    else $error("status beat pushed without closing the frame");

endmodule
